### design/two_link_arm_forward_kinematics_top_defines.svh
// Assertion helpers shared by the forward kinematics block.
// Each check samples on the rising edge of clock and is off while reset is high.
`ifndef TWO_LINK_ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH
`define TWO_LINK_ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH

// same-cycle implication
`define FK_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("forward kinematics check failed");

// next-cycle implication
`define FK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("forward kinematics check failed");

`endif

### design/tlafk_pkg.sv
package tlafk_pkg;

   localparam int ANGLE_BITS_DEF      = 16;
   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam int LEN_BITS    = 16;
   localparam int FIELD_BITS  = 16;
   localparam int TRIG_BITS   = 18;
   localparam int ROM_BITS    = 17;
   localparam int PROD_BITS   = LEN_BITS + 1 + TRIG_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int COORD_BITS  = 18;
   localparam int RND_SHIFT   = 16;

   localparam logic [LEN_BITS-1:0] LINK_RESET = 16'd8192;
   localparam logic [63:0]         HALF_PI_Q30 = 64'd1686629713;
   localparam int                  COORD_MAX = 131071;
   localparam int                  COORD_MIN_MAG = 131072;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index taken from the word address
   localparam logic LINK1_IDX = 1'b0;
   localparam logic LINK2_IDX = 1'b1;

   typedef struct packed {
      logic [LEN_BITS-1:0] link1;
      logic [LEN_BITS-1:0] link2;
   } link_cfg_type;

   // quarter-wave sine entry k of a 2^tbits table, unsigned Q.16, clamped to 1.0
   function automatic logic [ROM_BITS-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned tbits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] acc;
      logic [63:0]        r;
      x   = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tbits - 1))) >> tbits;
      x2  = (x * x) >> 30;
      acc = $signed(x);
      t   = ((x * x2) >> 30) / 64'd6;
      acc = acc - $signed(t);
      t   = ((t * x2) >> 30) / 64'd20;
      acc = acc + $signed(t);
      t   = ((t * x2) >> 30) / 64'd42;
      acc = acc - $signed(t);
      t   = ((t * x2) >> 30) / 64'd72;
      acc = acc + $signed(t);
      t   = ((t * x2) >> 30) / 64'd110;
      acc = acc - $signed(t);
      t   = ((t * x2) >> 30) / 64'd156;
      acc = acc + $signed(t);
      t   = ((t * x2) >> 30) / 64'd210;
      acc = acc - $signed(t);
      if (acc < 0) begin
         acc = 64'sd0;
      end
      r = ($unsigned(acc) + 64'd8192) >> 14;
      if (r > 64'd65536) begin
         r = 64'd65536;
      end
      return ROM_BITS'(r);
   endfunction

endpackage

### design/tlafk_sine.sv
module tlafk_sine #(
   parameter int ANGLE_BITS      = tlafk_pkg::ANGLE_BITS_DEF,
   parameter int SINE_TABLE_BITS = tlafk_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic [ANGLE_BITS-1:0]                angle,
   output logic signed [tlafk_pkg::TRIG_BITS-1:0] sine
);
   import tlafk_pkg::*;

   localparam int QBITS    = ANGLE_BITS - 2;
   localparam int TBL_N    = 1 << SINE_TABLE_BITS;
   localparam int IDX_BITS = SINE_TABLE_BITS + 1;

   typedef logic [ROM_BITS-1:0] rom_type [0:TBL_N];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k <= TBL_N; k++) begin
         r[k] = sine_entry(k, SINE_TABLE_BITS);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [1:0]          quad;
   logic [QBITS-1:0]    pos;
   logic [IDX_BITS-1:0] idx;
   logic [IDX_BITS-1:0] idx_mir;
   logic [ROM_BITS-1:0] mag;

   assign quad = angle[ANGLE_BITS-1 -: 2];
   assign pos  = angle[QBITS-1:0];

   generate
      if (QBITS > SINE_TABLE_BITS) begin : g_round
         localparam int SH = QBITS - SINE_TABLE_BITS;
         logic [QBITS:0] pos_rnd;
         // round half up; the top of a quadrant lands on the extra table entry
         assign pos_rnd = {1'b0, pos} + ((QBITS + 1)'(1) << (SH - 1));
         assign idx     = pos_rnd[QBITS -: IDX_BITS];
      end else begin : g_shift
         assign idx = IDX_BITS'({1'b0, pos}) << (SINE_TABLE_BITS - QBITS);
      end
   endgenerate

   // mirror in odd quadrants, negate in the lower half-turn
   assign idx_mir = quad[0] ? (IDX_BITS'(TBL_N) - idx) : idx;
   assign mag     = SINE_ROM[idx_mir];
   assign sine    = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

### design/tlafk_round.sv
module tlafk_round (
   input  logic signed [tlafk_pkg::SUM_BITS-1:0]   value,
   output logic signed [tlafk_pkg::COORD_BITS-1:0] coord
);
   import tlafk_pkg::*;

   localparam int RBITS = SUM_BITS - RND_SHIFT;
   localparam logic [RBITS-1:0] MAX_POS = RBITS'(COORD_MAX);
   localparam logic [RBITS-1:0] MAX_NEG = RBITS'(COORD_MIN_MAG);

   logic                neg;
   logic [SUM_BITS-1:0] mag;
   logic [SUM_BITS-1:0] mag_rnd;
   logic [RBITS-1:0]    rmag;

   assign neg     = value[SUM_BITS-1];
   assign mag     = neg ? $unsigned(-value) : $unsigned(value);
   // halves away from zero: round the magnitude, then restore the sign
   assign mag_rnd = mag + (SUM_BITS'(1) << (RND_SHIFT - 1));
   assign rmag    = mag_rnd[SUM_BITS-1:RND_SHIFT];

   always_comb begin
      if (!neg) begin
         coord = (rmag > MAX_POS) ? COORD_BITS'(MAX_POS) : $signed(rmag[COORD_BITS-1:0]);
      end else begin
         coord = (rmag > MAX_NEG) ? -$signed(COORD_BITS'(MAX_NEG))
                                  : -$signed(rmag[COORD_BITS-1:0]);
      end
   end

endmodule

### design/tlafk_csr.sv
module tlafk_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tlafk_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tlafk_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tlafk_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready,
   output tlafk_pkg::link_cfg_type             link_cfg
);
   import tlafk_pkg::*;

   logic [LEN_BITS-1:0] link1_ff;
   logic [LEN_BITS-1:0] link1_in;
   logic [LEN_BITS-1:0] link2_ff;
   logic [LEN_BITS-1:0] link2_in;
   logic                wr_en;
   logic                reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // word address selects the register, byte offset is ignored
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1];

   always_comb begin
      link1_in = link1_ff;
      link2_in = link2_ff;
      if (wr_en) begin
         case (reg_idx)
            LINK1_IDX: link1_in = csr_pwdata[LEN_BITS-1:0];
            LINK2_IDX: link2_in = csr_pwdata[LEN_BITS-1:0];
            default:   link1_in = link1_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         LINK1_IDX: csr_prdata = CSR_DATA_BITS'(link1_ff);
         LINK2_IDX: csr_prdata = CSR_DATA_BITS'(link2_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link1_ff <= LINK_RESET;
         link2_ff <= LINK_RESET;
      end else begin
         link1_ff <= link1_in;
         link2_ff <= link2_in;
      end
   end

   assign link_cfg.link1 = link1_ff;
   assign link_cfg.link2 = link2_ff;

endmodule

### design/two_link_arm_forward_kinematics_top.sv
// Two-link planar arm forward kinematics.
// req_ channel: one word per joint pair (shoulder and elbow binary angles).
// rsp_ channel: one word per request with elbow and tip points, signed Q4.14,
// in request order. csr_ port: link1_length at 0x0, link2_length at 0x4,
// unsigned Q2.14; write only while no word is in flight.
// Throughput: one word per cycle while rsp_tready is high, set by the
// four-stage pipe: angle register, sine/cosine table lookup, link-length
// multipliers, sum/round/saturate.
// Each stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up under a stall.
// When rsp_tready is low the result word holds and the pipe keeps filling;
// req_tready drops only once all four stages are full.
// Reset clears every valid bit and loads both link lengths with 0.5.
`include "two_link_arm_forward_kinematics_top_defines.svh"

module two_link_arm_forward_kinematics_top #(
   parameter int ANGLE_BITS      = tlafk_pkg::ANGLE_BITS_DEF,
   parameter int SINE_TABLE_BITS = tlafk_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // shoulder_angle, elbow_angle
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [71:0]                         rsp_tdata,  // elbow_x, elbow_y, tip_x, tip_y
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tlafk_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tlafk_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tlafk_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready
);
   import tlafk_pkg::*;

   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   link_cfg_type link_cfg;

   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic rdy4;

   logic [ANGLE_BITS-1:0] a1_word;
   logic [ANGLE_BITS-1:0] a2_word;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [ANGLE_BITS-1:0] s1_a1_ff;
   logic [ANGLE_BITS-1:0] s1_a1_in;
   logic [ANGLE_BITS-1:0] s1_a12_ff;
   logic [ANGLE_BITS-1:0] s1_a12_in;

   logic [ANGLE_BITS-1:0]        trig_angle [4];
   logic signed [TRIG_BITS-1:0]  trig_val [4];

   logic                         s2_valid_ff;
   logic                         s2_valid_in;
   logic signed [TRIG_BITS-1:0]  s2_trig_ff [4];
   logic signed [TRIG_BITS-1:0]  s2_trig_in [4];

   logic                         s3_valid_ff;
   logic                         s3_valid_in;
   logic signed [PROD_BITS-1:0]  s3_prod_ff [4];
   logic signed [PROD_BITS-1:0]  s3_prod_in [4];

   logic signed [SUM_BITS-1:0]   sum_val [4];
   logic signed [COORD_BITS-1:0] coord_val [4];

   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic signed [COORD_BITS-1:0] out_coord_ff [4];
   logic signed [COORD_BITS-1:0] out_coord_in [4];

   tlafk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .link_cfg    (link_cfg)
   );

   // ready ripples back from the result register
   assign rdy4       = !out_valid_ff || rsp_tready;
   assign rdy3       = !s3_valid_ff || rdy4;
   assign rdy2       = !s2_valid_ff || rdy3;
   assign rdy1       = !s1_valid_ff || rdy2;
   assign req_tready = rdy1;

   // stage 1: capture angles, form the summed angle with wrap
   assign a1_word   = ANGLE_BITS'(req_tdata[FIELD_BITS-1:0]);
   assign a2_word   = ANGLE_BITS'(req_tdata[2*FIELD_BITS-1:FIELD_BITS]);
   assign s1_valid_in = rdy1 ? req_tvalid : s1_valid_ff;
   assign s1_a1_in    = rdy1 ? a1_word : s1_a1_ff;
   assign s1_a12_in   = rdy1 ? (a1_word + a2_word) : s1_a12_ff;

   // stage 2: cos a1, sin a1, cos a12, sin a12
   assign trig_angle[0] = s1_a1_ff + QUARTER;
   assign trig_angle[1] = s1_a1_ff;
   assign trig_angle[2] = s1_a12_ff + QUARTER;
   assign trig_angle[3] = s1_a12_ff;

   generate
      for (genvar g = 0; g < 4; g++) begin : g_trig
         tlafk_sine #(
            .ANGLE_BITS      (ANGLE_BITS),
            .SINE_TABLE_BITS (SINE_TABLE_BITS)
         ) u_sine (
            .angle (trig_angle[g]),
            .sine  (trig_val[g])
         );
      end
   endgenerate

   assign s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;

   // stage 3: scale by link length, Q2.14 x Q.16 = Q30
   assign s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s2_trig_in[i] = rdy2 ? trig_val[i] : s2_trig_ff[i];
      end
      s3_prod_in[0] = rdy3 ? $signed({1'b0, link_cfg.link1}) * s2_trig_ff[0] : s3_prod_ff[0];
      s3_prod_in[1] = rdy3 ? $signed({1'b0, link_cfg.link1}) * s2_trig_ff[1] : s3_prod_ff[1];
      s3_prod_in[2] = rdy3 ? $signed({1'b0, link_cfg.link2}) * s2_trig_ff[2] : s3_prod_ff[2];
      s3_prod_in[3] = rdy3 ? $signed({1'b0, link_cfg.link2}) * s2_trig_ff[3] : s3_prod_ff[3];
   end

   // stage 4: add tip terms at full precision, round and saturate
   assign sum_val[0] = SUM_BITS'(s3_prod_ff[0]);
   assign sum_val[1] = SUM_BITS'(s3_prod_ff[1]);
   assign sum_val[2] = SUM_BITS'(s3_prod_ff[0]) + SUM_BITS'(s3_prod_ff[2]);
   assign sum_val[3] = SUM_BITS'(s3_prod_ff[1]) + SUM_BITS'(s3_prod_ff[3]);

   generate
      for (genvar g = 0; g < 4; g++) begin : g_rnd
         tlafk_round u_round (
            .value (sum_val[g]),
            .coord (coord_val[g])
         );
      end
   endgenerate

   assign out_valid_in = rdy4 ? s3_valid_ff : out_valid_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         out_coord_in[i] = rdy4 ? coord_val[i] : out_coord_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_a1_ff  <= s1_a1_in;
      s1_a12_ff <= s1_a12_in;
      for (int i = 0; i < 4; i++) begin
         s2_trig_ff[i]   <= s2_trig_in[i];
         s3_prod_ff[i]   <= s3_prod_in[i];
         out_coord_ff[i] <= out_coord_in[i];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_coord_ff[3], out_coord_ff[2], out_coord_ff[1], out_coord_ff[0]};

   `FK_ASSERT_IMPL(a_ready_when_drained, !rsp_tvalid, req_tready)
   `FK_ASSERT_NEXT(a_s1_moves_on, s1_valid_ff && rdy2, s2_valid_ff)
   `FK_ASSERT_NEXT(a_s3_reaches_out, s3_valid_ff && rdy4, rsp_tvalid)

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tlafk_pkg::*;

   localparam int ANGLE_W     = ANGLE_BITS_DEF;
   localparam int QUAD_BITS   = ANGLE_W - 2;
   localparam int SINE_SHIFT  = QUAD_BITS - SINE_TABLE_BITS_DEF;
   localparam int TABLE_LAST  = 1 << SINE_TABLE_BITS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 325;
   localparam int LINK_EPOCH  = 65;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] elbow_x;
      logic signed [COORD_BITS-1:0] elbow_y;
      logic signed [COORD_BITS-1:0] tip_x;
      logic signed [COORD_BITS-1:0] tip_y;
   } arm_pose_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] link1;
      logic [LEN_BITS-1:0] link2;
      logic [ANGLE_W-1:0]  shoulder;
      logic [ANGLE_W-1:0]  elbow;
      logic                known;
      arm_pose_type        pose;
   } arm_case_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [31:0]              req_tdata;   // shoulder_angle, elbow_angle
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [71:0]              rsp_tdata;   // elbow_x, elbow_y, tip_x, tip_y
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int unsigned         quarter_sine [0:TABLE_LAST];
   logic [LEN_BITS-1:0] link1_len;
   logic [LEN_BITS-1:0] link2_len;
   arm_pose_type        pending_poses [$];
   int                  error_count;
   int                  cycle_count;
   int                  sender_idle_pct;
   int                  receiver_stall_pct;
   int                  hold_request;
   int                  hold_left;

   // lengths, angles, typed pose where it is obvious
   arm_case_type directed_cases [0:19] = '{
      '{16'd8192,  16'd8192,  16'h0000, 16'h0000, 1'b1, '{8192, 0, 16384, 0}},
      '{16'd8192,  16'd8192,  16'h4000, 16'h0000, 1'b1, '{0, 8192, 0, 16384}},
      '{16'd8192,  16'd8192,  16'h8000, 16'h0000, 1'b1, '{-8192, 0, -16384, 0}},
      '{16'd8192,  16'd8192,  16'hC000, 16'h0000, 1'b1, '{0, -8192, 0, -16384}},
      '{16'd8192,  16'd8192,  16'h0000, 16'h8000, 1'b1, '{8192, 0, 0, 0}},
      '{16'd8192,  16'd8192,  16'hFFFF, 16'hFFFF, 1'b0, '{0, 0, 0, 0}},
      '{16'd8192,  16'd8192,  16'h0008, 16'h0008, 1'b0, '{0, 0, 0, 0}},
      '{16'd8192,  16'd8192,  16'h0007, 16'h0009, 1'b0, '{0, 0, 0, 0}},
      '{16'd8192,  16'd8192,  16'h3FF8, 16'h4008, 1'b0, '{0, 0, 0, 0}},
      '{16'd8192,  16'd8192,  16'h5555, 16'hAAAA, 1'b0, '{0, 0, 0, 0}},
      '{16'hFFFF,  16'hFFFF,  16'h0000, 16'h0000, 1'b1, '{65535, 0, 131070, 0}},
      '{16'hFFFF,  16'hFFFF,  16'h8000, 16'h0000, 1'b1, '{-65535, 0, -131070, 0}},
      '{16'hFFFF,  16'hFFFF,  16'h4000, 16'h4000, 1'b1, '{0, 65535, -65535, 65535}},
      '{16'hFFFF,  16'hFFFF,  16'h1234, 16'hFEDC, 1'b0, '{0, 0, 0, 0}},
      '{16'hFFFF,  16'hFFFF,  16'hFFFF, 16'h0001, 1'b0, '{0, 0, 0, 0}},
      '{16'h0000,  16'h0000,  16'h8000, 16'h7FFF, 1'b1, '{0, 0, 0, 0}},
      '{16'h0000,  16'h0000,  16'hFFFF, 16'hFFFF, 1'b1, '{0, 0, 0, 0}},
      '{16'h0001,  16'hFFFF,  16'h2000, 16'hE000, 1'b0, '{0, 0, 0, 0}},
      '{16'h0001,  16'hFFFF,  16'hC001, 16'h3FFF, 1'b0, '{0, 0, 0, 0}},
      '{16'd12345, 16'd54321, 16'h9ABC, 16'h1357, 1'b0, '{0, 0, 0, 0}}
   };

   two_link_arm_forward_kinematics_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // sin(pi/2 * k / N) by Taylor series in Q30, rounded to Q.16
   function automatic int unsigned quarter_sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] r;
      longint      acc;
      x    = (HALF_PI_Q30 * 64'(k) + 64'(TABLE_LAST / 2)) >> SINE_TABLE_BITS_DEF;
      x2   = (x * x) >> 30;
      term = x;
      acc  = 0;
      for (int n = 1; n <= 8; n++) begin
         if (n % 2 == 1) begin
            acc += longint'(term);
         end else begin
            acc -= longint'(term);
         end
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      end
      if (acc < 0) begin
         acc = 0;
      end
      r = (64'(acc) + 64'd8192) >> 14;
      if (r > 64'd65536) begin
         r = 64'd65536;
      end
      return 32'(r);
   endfunction

   // signed Q.16 sine of a binary angle
   function automatic longint binary_sine(input logic [ANGLE_W-1:0] angle);
      logic [1:0] quad;
      int         idx;
      quad = angle[ANGLE_W-1 -: 2];
      idx  = (int'(angle[QUAD_BITS-1:0]) + (1 << (SINE_SHIFT - 1))) >> SINE_SHIFT;
      if (idx > TABLE_LAST) begin
         idx = TABLE_LAST;
      end
      if (quad[0]) begin
         idx = TABLE_LAST - idx;
      end
      return quad[1] ? -longint'(quarter_sine[idx]) : longint'(quarter_sine[idx]);
   endfunction

   function automatic longint binary_cosine(input logic [ANGLE_W-1:0] angle);
      logic [ANGLE_W-1:0] shifted;
      shifted = angle + (ANGLE_W'(1) << QUAD_BITS);
      return binary_sine(shifted);
   endfunction

   // Q30 to Q14, halves away from zero, saturated
   function automatic logic signed [COORD_BITS-1:0] round_to_q14(input longint v);
      longint r;
      if (v >= 0) begin
         r = (v + 32768) >>> RND_SHIFT;
      end else begin
         r = -((-v + 32768) >>> RND_SHIFT);
      end
      if (r > COORD_MAX) begin
         r = COORD_MAX;
      end
      if (r < -longint'(COORD_MIN_MAG)) begin
         r = -longint'(COORD_MIN_MAG);
      end
      return COORD_BITS'(r);
   endfunction

   function automatic arm_pose_type forward_pose(input logic [ANGLE_W-1:0] shoulder,
                                                 input logic [ANGLE_W-1:0] elbow);
      logic [ANGLE_W-1:0] reach;
      longint             l1;
      longint             l2;
      longint             ex;
      longint             ey;
      arm_pose_type       pose;
      reach        = shoulder + elbow;
      l1           = longint'(link1_len);
      l2           = longint'(link2_len);
      ex           = l1 * binary_cosine(shoulder);
      ey           = l1 * binary_sine(shoulder);
      pose.elbow_x = round_to_q14(ex);
      pose.elbow_y = round_to_q14(ey);
      pose.tip_x   = round_to_q14(ex + l2 * binary_cosine(reach));
      pose.tip_y   = round_to_q14(ey + l2 * binary_sine(reach));
      return pose;
   endfunction

   function automatic logic [ANGLE_W-1:0] pick_angle();
      logic [QUAD_BITS-1:0] corners [0:8];
      corners = '{14'h0000, 14'h0001, 14'h0007, 14'h0008, 14'h0009,
                  14'h2000, 14'h3FF7, 14'h3FF8, 14'h3FFF};
      if ($urandom_range(3) == 0) begin
         return {2'($urandom_range(3)), corners[$urandom_range(8)]};
      end
      return ANGLE_W'($urandom);
   endfunction

   function automatic logic [LEN_BITS-1:0] pick_length();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return LEN_BITS'(1);
         3: return LINK_RESET;
         default: return LEN_BITS'($urandom);
      endcase
   endfunction

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // write the register, then read it back; junk in the upper half is dropped
   task automatic write_link_length(input logic idx, input logic [LEN_BITS-1:0] len);
      logic [CSR_DATA_BITS-1:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), len};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == LINK1_IDX) begin
         link1_len = len;
      end else begin
         link2_len = len;
      end
      if (readback !== CSR_DATA_BITS'(len)) begin
         error_count++;
         if (error_count <= 10) begin
            $display("link length readback at %0d: expected %0d, got %0d",
                     idx, len, readback);
         end
      end
   endtask

   task automatic set_links(input logic [LEN_BITS-1:0] l1, input logic [LEN_BITS-1:0] l2);
      if (l1 != link1_len || l2 != link2_len) begin
         drain_results();
         if (l1 != link1_len) begin
            write_link_length(LINK1_IDX, l1);
         end
         if (l2 != link2_len) begin
            write_link_length(LINK2_IDX, l2);
         end
      end
   endtask

   task automatic send_joint_pair(input logic [ANGLE_W-1:0] shoulder,
                                  input logic [ANGLE_W-1:0] elbow,
                                  input arm_pose_type expected);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {elbow, shoulder};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_poses.push_back(expected);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_pose
      arm_pose_type got;
      arm_pose_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.elbow_x = rsp_tdata[0*COORD_BITS +: COORD_BITS];
         got.elbow_y = rsp_tdata[1*COORD_BITS +: COORD_BITS];
         got.tip_x   = rsp_tdata[2*COORD_BITS +: COORD_BITS];
         got.tip_y   = rsp_tdata[3*COORD_BITS +: COORD_BITS];
         if (pending_poses.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected pose word: %0d %0d %0d %0d",
                        got.elbow_x, got.elbow_y, got.tip_x, got.tip_y);
            end
         end else begin
            want = pending_poses.pop_front();
            if (got.elbow_x !== want.elbow_x || got.elbow_y !== want.elbow_y ||
                got.tip_x !== want.tip_x || got.tip_y !== want.tip_y) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("pose mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           want.elbow_x, want.elbow_y, want.tip_x, want.tip_y,
                           got.elbow_x, got.elbow_y, got.tip_x, got.tip_y);
               end
            end
         end
      end
   end

   initial begin
      logic [ANGLE_W-1:0] a1;
      logic [ANGLE_W-1:0] a2;
      arm_case_type       row;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      error_count        = 0;
      cycle_count        = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 0;
      link1_len          = LINK_RESET;
      link2_len          = LINK_RESET;
      for (int k = 0; k <= TABLE_LAST; k++) begin
         quarter_sine[k] = quarter_sine_entry(k);
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_cases[i]) begin
         row = directed_cases[i];
         set_links(row.link1, row.link2);
         send_joint_pair(row.shoulder, row.elbow,
                         row.known ? row.pose : forward_pose(row.shoulder, row.elbow));
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % LINK_EPOCH == 0) begin
               set_links(pick_length(), pick_length());
            end
            // hold the result side so the pipe fills and backs up
            if ((phase == 0 && n == 40) || (phase == 3 && n == 150)) begin
               hold_request = 64;
            end
            // pause the sender until every word is back
            if (phase == 2 && n == 200) begin
               drain_results();
            end
            a1 = pick_angle();
            a2 = pick_angle();
            send_joint_pair(a1, a2, forward_pose(a1, a2));
         end
      end

      drain_results();
      repeat (16) @(posedge clock);
      error_count += pending_poses.size();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
